### sv/descriptor_block_move_sequencer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the descriptor block move sequencer
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef DESCRIPTOR_BLOCK_MOVE_SEQUENCER_ASSERT_SVH
`define DESCRIPTOR_BLOCK_MOVE_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising clock edge outside reset.
`define DBMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define DBMS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DBMS_ASSERT(label, clk, rst_n, prop, msg)
`define DBMS_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### sv/dbms_pkg.sv
// ---------------------------------------------------------------------------
// Descriptor block move sequencer package
// Shared constants, status codes and the result word type.
// ---------------------------------------------------------------------------
package dbms_pkg;

    // Default segment field widths.
    localparam int BASE_BITS_DEF   = 24;
    localparam int OFFSET_BITS_DEF = 16;

    // Width of the linear address outputs.
    localparam int ADDR_BITS = 25;

    // Action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [1:0] ST_IDLE = 2'd3;

    // One result word.
    typedef struct packed {
        logic                 move_valid;
        logic [ADDR_BITS-1:0] src_address;
        logic [ADDR_BITS-1:0] dst_address;
        logic                 last_move;
        logic [1:0]           status;
    } result_t;

endpackage

### sv/dbms_in_stage.sv
// ---------------------------------------------------------------------------
// Input register stage
// Captures one input word and holds it until the sequencer consumes it.
// ---------------------------------------------------------------------------
module dbms_in_stage #(
    parameter int BASE_BITS   = dbms_pkg::BASE_BITS_DEF,
    parameter int OFFSET_BITS = dbms_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [OFFSET_BITS-1:0] src_limit_raw,
    input  logic [BASE_BITS-1:0]   src_base,
    input  logic [OFFSET_BITS-1:0] src_offset,
    input  logic [OFFSET_BITS-1:0] dst_limit_raw,
    input  logic [BASE_BITS-1:0]   dst_base,
    input  logic [OFFSET_BITS-1:0] dst_offset,
    input  logic [OFFSET_BITS-1:0] byte_count,
    input  logic                   take,
    output logic                   s1_valid,
    output logic                   s1_action,
    output logic [OFFSET_BITS-1:0] s1_src_limit_raw,
    output logic [BASE_BITS-1:0]   s1_src_base,
    output logic [OFFSET_BITS-1:0] s1_src_offset,
    output logic [OFFSET_BITS-1:0] s1_dst_limit_raw,
    output logic [BASE_BITS-1:0]   s1_dst_base,
    output logic [OFFSET_BITS-1:0] s1_dst_offset,
    output logic [OFFSET_BITS-1:0] s1_byte_count
);
    import dbms_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic                   load;
    logic                   action_reg;
    logic [OFFSET_BITS-1:0] src_limit_raw_reg;
    logic [BASE_BITS-1:0]   src_base_reg;
    logic [OFFSET_BITS-1:0] src_offset_reg;
    logic [OFFSET_BITS-1:0] dst_limit_raw_reg;
    logic [BASE_BITS-1:0]   dst_base_reg;
    logic [OFFSET_BITS-1:0] dst_offset_reg;
    logic [OFFSET_BITS-1:0] byte_count_reg;

    // The stage takes a new word when empty or when its word moves on.
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg        <= action;
            src_limit_raw_reg <= src_limit_raw;
            src_base_reg      <= src_base;
            src_offset_reg    <= src_offset;
            dst_limit_raw_reg <= dst_limit_raw;
            dst_base_reg      <= dst_base;
            dst_offset_reg    <= dst_offset;
            byte_count_reg    <= byte_count;
        end
    end

    assign s1_valid         = valid_reg;
    assign s1_action        = action_reg;
    assign s1_src_limit_raw = src_limit_raw_reg;
    assign s1_src_base      = src_base_reg;
    assign s1_src_offset    = src_offset_reg;
    assign s1_dst_limit_raw = dst_limit_raw_reg;
    assign s1_dst_base      = dst_base_reg;
    assign s1_dst_offset    = dst_offset_reg;
    assign s1_byte_count    = byte_count_reg;

endmodule

### sv/dbms_seq.sv
// ---------------------------------------------------------------------------
// Move sequencer core
// Holds the latched descriptors and cursors and forms one result per word.
// ---------------------------------------------------------------------------
`include "descriptor_block_move_sequencer_assert.svh"

module dbms_seq #(
    parameter int BASE_BITS   = dbms_pkg::BASE_BITS_DEF,
    parameter int OFFSET_BITS = dbms_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   action,
    input  logic [OFFSET_BITS-1:0] src_limit_raw,
    input  logic [BASE_BITS-1:0]   src_base,
    input  logic [OFFSET_BITS-1:0] src_offset,
    input  logic [OFFSET_BITS-1:0] dst_limit_raw,
    input  logic [BASE_BITS-1:0]   dst_base,
    input  logic [OFFSET_BITS-1:0] dst_offset,
    input  logic [OFFSET_BITS-1:0] byte_count,
    output dbms_pkg::result_t      res
);
    import dbms_pkg::*;

    localparam int LIM_BITS = OFFSET_BITS + 1;
    localparam int SUM_BITS = ((BASE_BITS > OFFSET_BITS) ? BASE_BITS : OFFSET_BITS) + 1;
    localparam int WIDE_BITS = (SUM_BITS > ADDR_BITS) ? SUM_BITS : ADDR_BITS;

    logic                   active_reg;
    logic                   active_next;
    logic [LIM_BITS-1:0]    src_limit_reg;
    logic [LIM_BITS-1:0]    src_limit_next;
    logic [LIM_BITS-1:0]    dst_limit_reg;
    logic [LIM_BITS-1:0]    dst_limit_next;
    logic [BASE_BITS-1:0]   src_seg_base_reg;
    logic [BASE_BITS-1:0]   src_seg_base_next;
    logic [BASE_BITS-1:0]   dst_seg_base_reg;
    logic [BASE_BITS-1:0]   dst_seg_base_next;
    logic [OFFSET_BITS-1:0] src_cursor_reg;
    logic [OFFSET_BITS-1:0] src_cursor_next;
    logic [OFFSET_BITS-1:0] dst_cursor_reg;
    logic [OFFSET_BITS-1:0] dst_cursor_next;
    logic [LIM_BITS-1:0]    remaining_reg;
    logic [LIM_BITS-1:0]    remaining_next;

    logic [LIM_BITS-1:0]    new_src_limit;
    logic [LIM_BITS-1:0]    new_dst_limit;
    logic [LIM_BITS-1:0]    new_remaining;
    logic                   start_bad;
    logic                   cursor_bad;
    logic [WIDE_BITS-1:0]   src_sum;
    logic [WIDE_BITS-1:0]   dst_sum;

    // Descriptor decode for a start word.
    assign new_src_limit = {1'b0, src_limit_raw} + LIM_BITS'(1);
    assign new_dst_limit = {1'b0, dst_limit_raw} + LIM_BITS'(1);
    assign new_remaining = (byte_count == '0) ? {1'b1, {OFFSET_BITS{1'b0}}}
                                              : {1'b0, byte_count};
    assign start_bad = ({1'b0, src_offset} >= new_src_limit)
                    || ({1'b0, dst_offset} >= new_dst_limit);

    // Limit check and linear addresses for the current cursors.
    assign cursor_bad = ({1'b0, src_cursor_reg} >= src_limit_reg)
                     || ({1'b0, dst_cursor_reg} >= dst_limit_reg);
    assign src_sum = WIDE_BITS'(src_seg_base_reg) + WIDE_BITS'(src_cursor_reg);
    assign dst_sum = WIDE_BITS'(dst_seg_base_reg) + WIDE_BITS'(dst_cursor_reg);

    // Result and next state for the word in the input register.
    always_comb
    begin
        active_next       = active_reg;
        src_limit_next    = src_limit_reg;
        dst_limit_next    = dst_limit_reg;
        src_seg_base_next = src_seg_base_reg;
        dst_seg_base_next = dst_seg_base_reg;
        src_cursor_next   = src_cursor_reg;
        dst_cursor_next   = dst_cursor_reg;
        remaining_next    = remaining_reg;
        res               = '0;
        res.status        = ST_IDLE;

        unique case (action)
            ACT_START:
            begin
                src_limit_next    = new_src_limit;
                dst_limit_next    = new_dst_limit;
                src_seg_base_next = src_base;
                dst_seg_base_next = dst_base;
                src_cursor_next   = src_offset;
                dst_cursor_next   = dst_offset;
                remaining_next    = new_remaining;
                active_next       = !start_bad;
                res.status        = start_bad ? ST_FAIL : ST_BUSY;
            end
            ACT_NEXT:
            begin
                priority if (!active_reg)
                begin
                    res.status = ST_IDLE;
                end
                else if (cursor_bad)
                begin
                    active_next = 1'b0;
                    res.status  = ST_FAIL;
                end
                else
                begin
                    src_cursor_next = src_cursor_reg + OFFSET_BITS'(1);
                    dst_cursor_next = dst_cursor_reg + OFFSET_BITS'(1);
                    remaining_next  = remaining_reg - LIM_BITS'(1);
                    res.move_valid  = 1'b1;
                    res.src_address = src_sum[ADDR_BITS-1:0];
                    res.dst_address = dst_sum[ADDR_BITS-1:0];
                    if (remaining_reg == LIM_BITS'(1))
                    begin
                        active_next   = 1'b0;
                        res.last_move = 1'b1;
                        res.status    = ST_DONE;
                    end
                    else
                    begin
                        res.status = ST_BUSY;
                    end
                end
            end
            default:
            begin
                res.status = ST_IDLE;
            end
        endcase
    end

    // Control flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (step)
        begin
            active_reg <= active_next;
        end
    end

    // Descriptor and cursor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_limit_reg    <= '0;
            dst_limit_reg    <= '0;
            src_seg_base_reg <= '0;
            dst_seg_base_reg <= '0;
            src_cursor_reg   <= '0;
            dst_cursor_reg   <= '0;
            remaining_reg    <= '0;
        end
        else if (step)
        begin
            src_limit_reg    <= src_limit_next;
            dst_limit_reg    <= dst_limit_next;
            src_seg_base_reg <= src_seg_base_next;
            dst_seg_base_reg <= dst_seg_base_next;
            src_cursor_reg   <= src_cursor_next;
            dst_cursor_reg   <= dst_cursor_next;
            remaining_reg    <= remaining_next;
        end
    end

    // An active move never runs its cursors past the limits.
    `DBMS_NEVER(a_src_cursor_in_range, clk, rst_n, active_reg && ({1'b0, src_cursor_reg} > src_limit_reg), "source cursor beyond limit while active")
    `DBMS_NEVER(a_dst_cursor_in_range, clk, rst_n, active_reg && ({1'b0, dst_cursor_reg} > dst_limit_reg), "destination cursor beyond limit while active")
    // An active move always has bytes left.
    `DBMS_NEVER(a_remaining_nonzero, clk, rst_n, active_reg && (remaining_reg == '0), "active move with no bytes left")
    // A completion is flagged exactly on the last address pair.
    `DBMS_ASSERT(a_last_is_done, clk, rst_n, res.last_move == (res.status == ST_DONE), "last_move and completion status disagree")

endmodule

### sv/dbms_out_stage.sv
// ---------------------------------------------------------------------------
// Result register stage
// Holds one result word for the output channel and frees the input stage.
// ---------------------------------------------------------------------------
module dbms_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  dbms_pkg::result_t res_in,
    output logic              take,
    output logic              out_valid,
    input  logic              out_ready,
    output dbms_pkg::result_t res_out
);
    import dbms_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A word moves in when the register is empty or is being drained.
    assign take = s1_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result capture.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

### sv/descriptor_block_move_sequencer.sv
// A result word is offered once its input word has passed the input register
// and then the result register; a stalled receiver can hold it in between.
// Throughput: one word per cycle while out_ready is high. An active next word
// in limits has an address pair from the add-and-compare on registered cursors.
// Reset (rst_n low, asynchronous) empties both register stages and leaves
// the sequencer idle with all descriptors and cursors at zero.
// ---------------------------------------------------------------------------
// Descriptor block move sequencer
// Input register, sequencer core and result register in a two-stage pipe.
// ---------------------------------------------------------------------------
module descriptor_block_move_sequencer #(
    parameter int BASE_BITS   = dbms_pkg::BASE_BITS_DEF,
    parameter int OFFSET_BITS = dbms_pkg::OFFSET_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [OFFSET_BITS-1:0]         src_limit_raw,
    input  logic [BASE_BITS-1:0]           src_base,
    input  logic [OFFSET_BITS-1:0]         src_offset,
    input  logic [OFFSET_BITS-1:0]         dst_limit_raw,
    input  logic [BASE_BITS-1:0]           dst_base,
    input  logic [OFFSET_BITS-1:0]         dst_offset,
    input  logic [OFFSET_BITS-1:0]         byte_count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           move_valid,
    output logic [dbms_pkg::ADDR_BITS-1:0] src_address,
    output logic [dbms_pkg::ADDR_BITS-1:0] dst_address,
    output logic                           last_move,
    output logic [1:0]                     status
);
    import dbms_pkg::*;

    logic                   take;
    logic                   s1_valid;
    logic                   s1_action;
    logic [OFFSET_BITS-1:0] s1_src_limit_raw;
    logic [BASE_BITS-1:0]   s1_src_base;
    logic [OFFSET_BITS-1:0] s1_src_offset;
    logic [OFFSET_BITS-1:0] s1_dst_limit_raw;
    logic [BASE_BITS-1:0]   s1_dst_base;
    logic [OFFSET_BITS-1:0] s1_dst_offset;
    logic [OFFSET_BITS-1:0] s1_byte_count;
    result_t                seq_res;
    result_t                out_res;

    // Input register.
    dbms_in_stage #(
        .BASE_BITS   (BASE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .src_limit_raw    (src_limit_raw),
        .src_base         (src_base),
        .src_offset       (src_offset),
        .dst_limit_raw    (dst_limit_raw),
        .dst_base         (dst_base),
        .dst_offset       (dst_offset),
        .byte_count       (byte_count),
        .take             (take),
        .s1_valid         (s1_valid),
        .s1_action        (s1_action),
        .s1_src_limit_raw (s1_src_limit_raw),
        .s1_src_base      (s1_src_base),
        .s1_src_offset    (s1_src_offset),
        .s1_dst_limit_raw (s1_dst_limit_raw),
        .s1_dst_base      (s1_dst_base),
        .s1_dst_offset    (s1_dst_offset),
        .s1_byte_count    (s1_byte_count)
    );

    // Sequencer core; its state advances when the result register loads.
    dbms_seq #(
        .BASE_BITS   (BASE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (take),
        .action        (s1_action),
        .src_limit_raw (s1_src_limit_raw),
        .src_base      (s1_src_base),
        .src_offset    (s1_src_offset),
        .dst_limit_raw (s1_dst_limit_raw),
        .dst_base      (s1_dst_base),
        .dst_offset    (s1_dst_offset),
        .byte_count    (s1_byte_count),
        .res           (seq_res)
    );

    // Result register.
    dbms_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .res_in    (seq_res),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (out_res)
    );

    assign move_valid  = out_res.move_valid;
    assign src_address = out_res.src_address;
    assign dst_address = out_res.dst_address;
    assign last_move   = out_res.last_move;
    assign status      = out_res.status;

endmodule

### verif/descriptor_block_move_sequencer_test.sv
// ---------------------------------------------------------------------------
// Descriptor block move sequencer testbench
// Drives start and next words through the valid/ready input channel and
// checks every result word against a cycle-free model of the sequencer, or
// against the table for typed directed words. Random move sequences run under
// four idling phases on both sides; a short directed table opens the first.
// ---------------------------------------------------------------------------
module descriptor_block_move_sequencer_test;

    import dbms_pkg::*;

    localparam int OW             = OFFSET_BITS_DEF;
    localparam int BW             = BASE_BITS_DEF;
    localparam int PHASE_WORDS    = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;

    // One input word as the sender sees it.
    typedef struct packed {
        logic          action;
        logic [OW-1:0] src_limit_raw;
        logic [BW-1:0] src_base;
        logic [OW-1:0] src_offset;
        logic [OW-1:0] dst_limit_raw;
        logic [BW-1:0] dst_base;
        logic [OW-1:0] dst_offset;
        logic [OW-1:0] byte_count;
    } move_word_t;

    // One row of the directed table.
    typedef struct {
        move_word_t word;
        bit         typed;
        result_t    res;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [OW-1:0]        src_limit_raw;
    logic [BW-1:0]        src_base;
    logic [OW-1:0]        src_offset;
    logic [OW-1:0]        dst_limit_raw;
    logic [BW-1:0]        dst_base;
    logic [OW-1:0]        dst_offset;
    logic [OW-1:0]        byte_count;
    logic                 out_valid;
    logic                 out_ready;
    logic                 move_valid;
    logic [ADDR_BITS-1:0] src_address;
    logic [ADDR_BITS-1:0] dst_address;
    logic                 last_move;
    logic [1:0]           status;

    // Shadow copy of the sequencer state.
    logic                 seq_active;
    logic [OW:0]          seq_src_limit;
    logic [OW:0]          seq_dst_limit;
    logic [BW-1:0]        seq_src_base;
    logic [BW-1:0]        seq_dst_base;
    logic [OW-1:0]        seq_src_cursor;
    logic [OW-1:0]        seq_dst_cursor;
    logic [OW:0]          seq_bytes_left;

    result_t              expected_moves[$];
    dir_row_t             dir_rows[$];
    bit                   word_typed;
    result_t              word_result;
    int                   fail_count;
    int                   idle_cycles;
    int                   words_sent;
    int                   send_gap_pct;
    int                   stall_pct;

    descriptor_block_move_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .src_limit_raw (src_limit_raw),
        .src_base      (src_base),
        .src_offset    (src_offset),
        .dst_limit_raw (dst_limit_raw),
        .dst_base      (dst_base),
        .dst_offset    (dst_offset),
        .byte_count    (byte_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .move_valid    (move_valid),
        .src_address   (src_address),
        .dst_address   (dst_address),
        .last_move     (last_move),
        .status        (status)
    );

    // Advances the shadow state by one word and returns the result it causes.
    function automatic result_t predict_move(input move_word_t w);
        result_t r;
        r = '0;
        if (w.action == ACT_START)
        begin
            seq_src_limit  = {1'b0, w.src_limit_raw} + (OW+1)'(1);
            seq_dst_limit  = {1'b0, w.dst_limit_raw} + (OW+1)'(1);
            seq_src_base   = w.src_base;
            seq_dst_base   = w.dst_base;
            seq_src_cursor = w.src_offset;
            seq_dst_cursor = w.dst_offset;
            seq_bytes_left = (w.byte_count == '0) ? {1'b1, {OW{1'b0}}}
                                                  : {1'b0, w.byte_count};
            if ({1'b0, seq_src_cursor} >= seq_src_limit ||
                {1'b0, seq_dst_cursor} >= seq_dst_limit)
            begin
                seq_active = 1'b0;
                r.status   = ST_FAIL;
            end
            else
            begin
                seq_active = 1'b1;
                r.status   = ST_BUSY;
            end
        end
        else if (!seq_active)
        begin
            r.status = ST_IDLE;
        end
        else if ({1'b0, seq_src_cursor} >= seq_src_limit ||
                 {1'b0, seq_dst_cursor} >= seq_dst_limit)
        begin
            // A segment ran out while bytes were still left.
            seq_active = 1'b0;
            r.status   = ST_FAIL;
        end
        else
        begin
            r.move_valid   = 1'b1;
            r.src_address  = {1'b0, seq_src_base} + {{(ADDR_BITS-OW){1'b0}}, seq_src_cursor};
            r.dst_address  = {1'b0, seq_dst_base} + {{(ADDR_BITS-OW){1'b0}}, seq_dst_cursor};
            seq_src_cursor = seq_src_cursor + OW'(1);
            seq_dst_cursor = seq_dst_cursor + OW'(1);
            seq_bytes_left = seq_bytes_left - (OW+1)'(1);
            if (seq_bytes_left == '0)
            begin
                seq_active  = 1'b0;
                r.last_move = 1'b1;
                r.status    = ST_DONE;
            end
            else
            begin
                r.status = ST_BUSY;
            end
        end
        return r;
    endfunction

    function automatic move_word_t start_word(input logic [OW-1:0] sl, input logic [BW-1:0] sb,
                                              input logic [OW-1:0] so, input logic [OW-1:0] dl,
                                              input logic [BW-1:0] db, input logic [OW-1:0] dof,
                                              input logic [OW-1:0] cnt);
        move_word_t w;
        w.action        = ACT_START;
        w.src_limit_raw = sl;
        w.src_base      = sb;
        w.src_offset    = so;
        w.dst_limit_raw = dl;
        w.dst_base      = db;
        w.dst_offset    = dof;
        w.byte_count    = cnt;
        return w;
    endfunction

    // A next word carries random descriptor fields, which the block ignores.
    function automatic move_word_t next_word();
        move_word_t w;
        w = start_word(OW'($urandom), BW'($urandom), OW'($urandom), OW'($urandom),
                       BW'($urandom), OW'($urandom), OW'($urandom));
        w.action = ACT_NEXT;
        return w;
    endfunction

    function automatic result_t no_pair(input logic [1:0] st);
        result_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    function automatic result_t with_pair(input logic [ADDR_BITS-1:0] sa,
                                          input logic [ADDR_BITS-1:0] da,
                                          input logic lst, input logic [1:0] st);
        result_t r;
        r.move_valid  = 1'b1;
        r.src_address = sa;
        r.dst_address = da;
        r.last_move   = lst;
        r.status      = st;
        return r;
    endfunction

    task automatic add_row(input move_word_t w, input bit typed, input result_t r);
        dir_row_t row;
        row.word  = w;
        row.typed = typed;
        row.res   = r;
        dir_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Presents one word after a random gap and returns at the falling edge
    // that follows its acceptance.
    task automatic send_word(input move_word_t w, input bit typed, input result_t r);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= w.action;
        src_limit_raw <= w.src_limit_raw;
        src_base      <= w.src_base;
        src_offset    <= w.src_offset;
        dst_limit_raw <= w.dst_limit_raw;
        dst_base      <= w.dst_base;
        dst_offset    <= w.dst_offset;
        byte_count    <= w.byte_count;
        word_typed    <= typed;
        word_result   <= r;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_moves.size() != 0)
            @(negedge clk);
    endtask

    // Picks a segment limit and an offset, mostly inside the segment.
    task automatic pick_segment(output logic [OW-1:0] lim, output logic [OW-1:0] ofs);
        int sel;
        int span;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            lim = OW'($urandom);
        else if (sel < 70)
            lim = '1;
        else
            lim = OW'($urandom_range(0, 63));
        span = (lim < OW'(40)) ? int'(lim) : 40;
        ofs  = lim - OW'($urandom_range(0, span));
        if ($urandom_range(0, 99) < 8)
            ofs = OW'($urandom);
    endtask

    // One random move: mostly a well-formed start followed by its next words,
    // sometimes a start with random fields or stray next words.
    task automatic run_sequence();
        move_word_t    w;
        logic [OW-1:0] sl;
        logic [OW-1:0] so;
        logic [OW-1:0] dl;
        logic [OW-1:0] dof;
        logic [OW-1:0] cnt;
        int            kind;
        int            n;
        int            sel;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 4)
            drain_results();
        if (kind < 70)
        begin
            pick_segment(sl, so);
            pick_segment(dl, dof);
            sel = $urandom_range(0, 99);
            if (sel < 90)
                cnt = OW'($urandom_range(1, 32));
            else if (sel < 95)
                cnt = '0;
            else
                cnt = OW'($urandom);
            w = start_word(sl, BW'($urandom), so, dl, BW'($urandom), dof, cnt);
            send_word(w, 1'b0, no_pair(ST_BUSY));
            n = 0;
            while (seq_active && n < 40 && $urandom_range(0, 99) >= 3)
            begin
                send_word(next_word(), 1'b0, no_pair(ST_BUSY));
                n++;
            end
            if ($urandom_range(0, 99) < 30)
                send_word(next_word(), 1'b0, no_pair(ST_BUSY));
        end
        else if (kind < 85)
        begin
            w = next_word();
            w.action = ACT_START;
            send_word(w, 1'b0, no_pair(ST_BUSY));
            n = $urandom_range(0, 3);
            repeat (n)
                send_word(next_word(), 1'b0, no_pair(ST_BUSY));
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                send_word(next_word(), 1'b0, no_pair(ST_BUSY));
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: ready stalls at the rate of the current phase.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Records each accepted input word and checks each accepted result word.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (in_valid && in_ready)
            begin
                pred = predict_move({action, src_limit_raw, src_base, src_offset,
                                     dst_limit_raw, dst_base, dst_offset, byte_count});
                expected_moves.push_back(word_typed ? word_result : pred);
            end
            if (out_valid && out_ready)
            begin
                got = {move_valid, src_address, dst_address, last_move, status};
                if (expected_moves.size() == 0)
                begin
                    $error("result word with no expectation waiting: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_moves.pop_front();
                    check_field("move_valid", 32'(want.move_valid), 32'(got.move_valid));
                    check_field("src_address", 32'(want.src_address), 32'(got.src_address));
                    check_field("dst_address", 32'(want.dst_address), 32'(got.dst_address));
                    check_field("last_move", 32'(want.last_move), 32'(got.last_move));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has been accepted for too long.
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus.
    initial
    begin
        in_valid       = 1'b0;
        action         = ACT_NEXT;
        src_limit_raw  = '0;
        src_base       = '0;
        src_offset     = '0;
        dst_limit_raw  = '0;
        dst_base       = '0;
        dst_offset     = '0;
        byte_count     = '0;
        word_typed     = 1'b0;
        word_result    = '0;
        rst_n          = 1'b0;
        fail_count     = 0;
        idle_cycles    = 0;
        words_sent     = 0;
        send_gap_pct   = 0;
        stall_pct      = 0;
        seq_active     = 1'b0;
        seq_src_limit  = '0;
        seq_dst_limit  = '0;
        seq_src_base   = '0;
        seq_dst_base   = '0;
        seq_src_cursor = '0;
        seq_dst_cursor = '0;
        seq_bytes_left = '0;

        // Next while idle after reset, then starts rejected on either side.
        add_row(next_word(), 1'b1, no_pair(ST_IDLE));
        add_row(start_word(16'h0010, 24'h000100, 16'h0011, 16'h0010, 24'h000200, 16'h0000,
                           16'd4), 1'b1, no_pair(ST_FAIL));
        add_row(start_word(16'h0010, 24'h000100, 16'h0000, 16'h0000, 24'h000200, 16'h0001,
                           16'd4), 1'b1, no_pair(ST_FAIL));
        add_row(next_word(), 1'b1, no_pair(ST_IDLE));
        // All fields at their maximum: the offsets wrap inside a full segment.
        add_row(start_word('1, '1, '1, '1, '1, '1, 16'd2), 1'b1, no_pair(ST_BUSY));
        add_row(next_word(), 1'b1, with_pair(25'h100FFFE, 25'h100FFFE, 1'b0, ST_BUSY));
        add_row(next_word(), 1'b1, with_pair(25'h0FFFFFF, 25'h0FFFFFF, 1'b1, ST_DONE));
        add_row(next_word(), 1'b1, no_pair(ST_IDLE));
        // All fields zero: a one-byte segment with a full-size count runs out.
        add_row(start_word('0, '0, '0, '0, '0, '0, '0), 1'b1, no_pair(ST_BUSY));
        add_row(next_word(), 1'b1, with_pair('0, '0, 1'b0, ST_BUSY));
        add_row(next_word(), 1'b1, no_pair(ST_FAIL));
        // Single-byte move.
        add_row(start_word(16'h00FF, 24'h123456, 16'h0010, 16'h0FFF, 24'hABCDEF, 16'h0020,
                           16'd1), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        // A move dropped part way through by a fresh start, which then completes.
        add_row(start_word(16'h0003, 24'h400000, 16'h0000, 16'h7FFF, 24'h800000, 16'h7FF0,
                           16'd5), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        add_row(start_word(16'h8000, 24'h0F0F0F, 16'h7FFE, 16'h0005, 24'hF0F0F0, 16'h0003,
                           16'd3), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        // Destination limit reached with bytes left.
        add_row(start_word(16'hFFFF, 24'h000000, 16'h1234, 16'h0001, 24'hFFFFFF, 16'h0001,
                           16'd8), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));
        add_row(next_word(), 1'b0, no_pair(ST_BUSY));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 54;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 54;
                end
                default:
                begin
                    send_gap_pct = 24;
                    stall_pct    = 24;
                end
            endcase
            if (phase == 0)
            begin
                foreach (dir_rows[i])
                    send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
            end
            words_sent = 0;
            while (words_sent < PHASE_WORDS)
                run_sequence();
            drain_results();
        end

        // Let any stray result word show itself before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_moves.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
